@@ rtl/talca_pkg.sv @@
// Shared types, constants and helpers of the tree ancestor and common-ancestor engine.
package talca_pkg;

  localparam int ID_W       = 10;
  localparam int DEPTH_W    = 10;
  localparam int DIST_W     = 11;
  localparam int EXT_W      = 17;
  localparam int LVL_W      = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;

  typedef enum logic [1:0] {
    MODE_ATTACH = 2'd0,
    MODE_LCA    = 2'd1,
    MODE_KTH    = 2'd2,
    MODE_DIST   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_PAST   = 2'd3
  } status_t;

  typedef logic [ID_W-1:0] node_id_t;

  typedef struct packed {
    logic                 en;
    node_id_t             id;
    logic [DEPTH_W-1:0]   depth;
  } node_wr_t;

  typedef struct packed {
    logic                 in_tree;
    logic [DEPTH_W-1:0]   depth;
  } node_rd_t;

  typedef struct packed {
    logic [LVL_W-1:0]     lvl;
    node_id_t             id;
  } anc_req_t;

  typedef struct packed {
    logic                 ok;
    node_id_t             anc;
  } anc_entry_t;

  typedef struct packed {
    logic                 en;
    anc_req_t             loc;
    anc_entry_t           data;
  } anc_wr_t;

  function automatic logic id_in_range(node_id_t id, int unsigned nodes);
    return EXT_W'(id) < EXT_W'(nodes);
  endfunction

endpackage

@@ rtl/talca_node_store.sv @@
// Node store: attach mark and depth per node, with the clearing pass after reset or a root write.
module talca_node_store #(
  parameter int NODES = talca_pkg::NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear_req,
  input  talca_pkg::node_id_t  root,
  input  talca_pkg::node_id_t  rd_id,
  input  talca_pkg::node_wr_t  wr,
  output logic                 busy,
  output talca_pkg::node_rd_t  rd
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  typedef struct packed {
    logic                           mark;
    logic [talca_pkg::DEPTH_W-1:0]  depth;
  } entry_t;

  entry_t                        mem [0:NODES-1];
  logic                          busy_r;
  logic [AW-1:0]                 sweep_r;
  entry_t                        rd_q_r;
  logic                          rd_ok_r;
  logic [talca_pkg::EXT_W-1:0]   root_ext;
  logic [talca_pkg::EXT_W-1:0]   rd_ext;
  logic [talca_pkg::EXT_W-1:0]   wr_ext;
  logic                          root_ok;
  logic                          we;
  logic [AW-1:0]                 wa;
  entry_t                        wd;

  assign root_ext = talca_pkg::EXT_W'(root);
  assign rd_ext   = talca_pkg::EXT_W'(rd_id);
  assign wr_ext   = talca_pkg::EXT_W'(wr.id);
  assign root_ok  = talca_pkg::id_in_range(root, NODES);

  always_comb begin
    if (busy_r) begin
      we       = 1'b1;
      wa       = sweep_r;
      wd.mark  = root_ok && (root_ext[AW-1:0] == sweep_r);
      wd.depth = '0;
    end else begin
      we       = wr.en;
      wa       = wr_ext[AW-1:0];
      wd.mark  = 1'b1;
      wd.depth = wr.depth;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      sweep_r <= '0;
    end else if (clear_req) begin
      busy_r  <= 1'b1;
      sweep_r <= '0;
    end else if (busy_r) begin
      if (sweep_r == AW'(NODES - 1)) begin
        busy_r <= 1'b0;
      end else begin
        sweep_r <= sweep_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q_r  <= mem[rd_ext[AW-1:0]];
    rd_ok_r <= talca_pkg::id_in_range(rd_id, NODES);
  end

  assign busy       = busy_r;
  assign rd.in_tree = rd_ok_r && rd_q_r.mark;
  assign rd.depth   = rd_q_r.depth;

endmodule

@@ rtl/talca_anc_store.sv @@
// Ancestor store: one entry per level and node, one write port and two registered read ports.
module talca_anc_store #(
  parameter int NODES  = talca_pkg::NODES_DEF,
  parameter int LEVELS = talca_pkg::LEVELS_DEF
) (
  input  logic                   clk,
  input  talca_pkg::node_id_t    root,
  input  talca_pkg::anc_req_t    rd0_req,
  input  talca_pkg::anc_req_t    rd1_req,
  input  talca_pkg::anc_wr_t     wr,
  output talca_pkg::anc_entry_t  rd0,
  output talca_pkg::anc_entry_t  rd1
);

  localparam int AW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADEPTH = LEVELS * (1 << AW);
  localparam int AAW    = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;

  talca_pkg::anc_entry_t  mem [0:ADEPTH-1];
  talca_pkg::anc_entry_t  q0_r;
  talca_pkg::anc_entry_t  q1_r;
  logic                   hit0_r;
  logic                   hit1_r;

  function automatic logic [AAW-1:0] addr_of(talca_pkg::anc_req_t r);
    logic [talca_pkg::EXT_W-1:0] ext;
    ext = talca_pkg::EXT_W'(r.id);
    return AAW'({r.lvl[LW-1:0], ext[AW-1:0]});
  endfunction

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[addr_of(wr.loc)] <= wr.data;
    end
    q0_r   <= mem[addr_of(rd0_req)];
    q1_r   <= mem[addr_of(rd1_req)];
    hit0_r <= (rd0_req.id == root);
    hit1_r <= (rd1_req.id == root);
  end

  // The root has no ancestors, whatever its entries last held.
  assign rd0.ok  = q0_r.ok && !hit0_r;
  assign rd0.anc = q0_r.anc;
  assign rd1.ok  = q1_r.ok && !hit1_r;
  assign rd1.anc = q1_r.anc;

endmodule

@@ rtl/talca_ctrl.sv @@
// Sequencer: runs attach, climb and common-ancestor walks over the two stores and holds the result.
module talca_ctrl #(
  parameter int NODES  = talca_pkg::NODES_DEF,
  parameter int LEVELS = talca_pkg::LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  talca_pkg::mode_t                  in_mode,
  input  talca_pkg::node_id_t               in_node_a,
  input  talca_pkg::node_id_t               in_node_b,
  input  logic [talca_pkg::ID_W-1:0]        in_k_steps,
  input  logic                              cfg_wr_en,
  input  logic                              node_busy,
  output talca_pkg::node_id_t               node_rd_id,
  output talca_pkg::node_wr_t               node_wr,
  input  talca_pkg::node_rd_t               node_rd,
  output talca_pkg::anc_req_t               anc_rd0_req,
  output talca_pkg::anc_req_t               anc_rd1_req,
  output talca_pkg::anc_wr_t                anc_wr,
  input  talca_pkg::anc_entry_t             anc_rd0,
  input  talca_pkg::anc_entry_t             anc_rd1,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output talca_pkg::status_t                out_status,
  output talca_pkg::node_id_t               out_node,
  output logic [talca_pkg::DIST_W-1:0]      out_dist
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_A, S_B, S_ATT, S_CL, S_CLW, S_CMP,
    S_LQ, S_LW, S_FQ, S_FW, S_FD, S_EMIT
  } state_t;

  state_t                            state_r;
  talca_pkg::mode_t                  mode_r;
  talca_pkg::node_id_t               a_r;
  talca_pkg::node_id_t               b_r;
  logic [talca_pkg::ID_W-1:0]        k_r;
  logic [talca_pkg::DEPTH_W-1:0]     da_r;
  logic [talca_pkg::DEPTH_W-1:0]     db_r;
  logic [talca_pkg::DEPTH_W-1:0]     du_r;
  talca_pkg::node_id_t               u_r;
  talca_pkg::node_id_t               v_r;
  logic [talca_pkg::ID_W-1:0]        kr_r;
  logic [LW-1:0]                     lvl_r;
  logic                              ok_r;
  talca_pkg::status_t                st_r;
  talca_pkg::node_id_t               res_r;
  logic [talca_pkg::DIST_W-1:0]      dist_r;
  logic                              out_valid_r;
  talca_pkg::status_t                out_status_r;
  talca_pkg::node_id_t               out_node_r;
  logic [talca_pkg::DIST_W-1:0]      out_dist_r;

  logic [talca_pkg::EXT_W-1:0]       step;
  logic                              step_fits;
  logic                              e_ok;
  logic [talca_pkg::DEPTH_W-1:0]     dn_sel;
  logic [talca_pkg::DIST_W:0]        dist_calc;

  assign in_tready = (state_r == S_IDLE) && !node_busy && !cfg_wr_en;

  assign step      = talca_pkg::EXT_W'(1) << lvl_r;
  assign step_fits = talca_pkg::EXT_W'(kr_r) >= step;
  assign e_ok      = ok_r && anc_rd0.ok;
  assign dn_sel    = (state_r == S_FD) ? node_rd.depth : du_r;
  assign dist_calc = (talca_pkg::DIST_W+1)'(da_r) + (talca_pkg::DIST_W+1)'(db_r)
                   - {1'b0, dn_sel, 1'b0};

  always_comb begin
    case (state_r)
      S_IDLE:  node_rd_id = in_node_a;
      S_A:     node_rd_id = b_r;
      S_FW:    node_rd_id = anc_rd0.anc;
      default: node_rd_id = a_r;
    endcase

    node_wr.en    = (state_r == S_B) && (mode_r == talca_pkg::MODE_ATTACH) && !node_rd.in_tree;
    node_wr.id    = b_r;
    node_wr.depth = da_r + talca_pkg::DEPTH_W'(1);

    anc_rd0_req = '{lvl: talca_pkg::LVL_W'(lvl_r), id: v_r};
    anc_rd1_req = '{lvl: talca_pkg::LVL_W'(lvl_r), id: v_r};
    anc_wr      = '{en: 1'b0, loc: '{lvl: talca_pkg::LVL_W'(lvl_r), id: b_r},
                    data: '{ok: e_ok, anc: e_ok ? anc_rd0.anc : '0}};
    case (state_r)
      S_B: begin
        anc_rd0_req = '{lvl: '0, id: a_r};
        anc_wr.en   = node_wr.en;
        anc_wr.loc  = '{lvl: '0, id: b_r};
        anc_wr.data = '{ok: 1'b1, anc: a_r};
      end
      S_ATT: begin
        anc_rd0_req = '{lvl: talca_pkg::LVL_W'(lvl_r), id: anc_rd0.anc};
        anc_wr.en   = 1'b1;
      end
      S_LQ: begin
        anc_rd0_req = '{lvl: talca_pkg::LVL_W'(lvl_r), id: u_r};
      end
      S_FQ: begin
        anc_rd0_req = '{lvl: '0, id: u_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            mode_r  <= in_mode;
            a_r     <= in_node_a;
            b_r     <= in_node_b;
            k_r     <= in_k_steps;
            st_r    <= talca_pkg::ST_OK;
            res_r   <= '0;
            dist_r  <= '0;
            state_r <= S_A;
          end
        end
        S_A: begin
          da_r <= node_rd.depth;
          if (!node_rd.in_tree) begin
            st_r    <= talca_pkg::ST_ABSENT;
            state_r <= S_EMIT;
          end else begin
            case (mode_r)
              talca_pkg::MODE_ATTACH: begin
                if (!talca_pkg::id_in_range(b_r, NODES)) begin
                  st_r    <= talca_pkg::ST_ABSENT;
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_B;
                end
              end
              talca_pkg::MODE_KTH: begin
                if (k_r > node_rd.depth) begin
                  st_r    <= talca_pkg::ST_PAST;
                  state_r <= S_EMIT;
                end else begin
                  v_r     <= a_r;
                  kr_r    <= k_r;
                  lvl_r   <= LW'(LEVELS - 1);
                  state_r <= S_CL;
                end
              end
              default: state_r <= S_B;
            endcase
          end
        end
        S_B: begin
          db_r <= node_rd.depth;
          if (mode_r == talca_pkg::MODE_ATTACH) begin
            if (node_rd.in_tree) begin
              st_r    <= talca_pkg::ST_DUP;
              state_r <= S_EMIT;
            end else begin
              ok_r  <= 1'b1;
              lvl_r <= LW'(1);
              if (LEVELS == 1) begin
                state_r <= S_EMIT;
              end else begin
                state_r <= S_ATT;
              end
            end
          end else if (!node_rd.in_tree) begin
            st_r    <= talca_pkg::ST_ABSENT;
            state_r <= S_EMIT;
          end else begin
            if (da_r > node_rd.depth) begin
              u_r  <= b_r;
              du_r <= node_rd.depth;
              v_r  <= a_r;
              kr_r <= da_r - node_rd.depth;
            end else begin
              u_r  <= a_r;
              du_r <= da_r;
              v_r  <= b_r;
              kr_r <= node_rd.depth - da_r;
            end
            lvl_r   <= LW'(LEVELS - 1);
            state_r <= S_CL;
          end
        end
        S_ATT: begin
          ok_r <= e_ok;
          if (lvl_r == LW'(LEVELS - 1)) begin
            state_r <= S_EMIT;
          end else begin
            lvl_r <= lvl_r + LW'(1);
          end
        end
        S_CL: begin
          if (kr_r == '0) begin
            if (mode_r == talca_pkg::MODE_KTH) begin
              res_r   <= v_r;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_CMP;
            end
          end else if (step_fits) begin
            state_r <= S_CLW;
          end else if (lvl_r != '0) begin
            lvl_r <= lvl_r - LW'(1);
          end
        end
        S_CLW: begin
          if (anc_rd0.ok) begin
            v_r  <= anc_rd0.anc;
            kr_r <= kr_r - step[talca_pkg::ID_W-1:0];
          end else if (lvl_r != '0) begin
            lvl_r <= lvl_r - LW'(1);
          end
          state_r <= S_CL;
        end
        S_CMP: begin
          if (u_r == v_r) begin
            res_r <= u_r;
            if (mode_r == talca_pkg::MODE_DIST) begin
              dist_r <= dist_calc[talca_pkg::DIST_W-1:0];
            end
            state_r <= S_EMIT;
          end else begin
            lvl_r   <= LW'(LEVELS - 1);
            state_r <= S_LQ;
          end
        end
        S_LQ: state_r <= S_LW;
        S_LW: begin
          if (anc_rd0.ok && anc_rd1.ok && (anc_rd0.anc != anc_rd1.anc)) begin
            u_r     <= anc_rd0.anc;
            v_r     <= anc_rd1.anc;
            state_r <= S_LQ;
          end else if (lvl_r == '0) begin
            state_r <= S_FQ;
          end else begin
            lvl_r   <= lvl_r - LW'(1);
            state_r <= S_LQ;
          end
        end
        S_FQ: state_r <= S_FW;
        S_FW: begin
          res_r <= anc_rd0.anc;
          if (mode_r == talca_pkg::MODE_DIST) begin
            state_r <= S_FD;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_FD: begin
          dist_r  <= dist_calc[talca_pkg::DIST_W-1:0];
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_node_r   <= res_r;
            out_dist_r   <= dist_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_node   = out_node_r;
  assign out_dist   = out_dist_r;

endmodule

@@ rtl/tree_ancestor_lca_engine_core.sv @@
// Top level of the binary-lifting tree ancestor and lowest-common-ancestor engine.
//
//   Channel  Direction  Ports                        Contents
//   in_      slave      tvalid tready tdata tuser    attach or query request
//   out_     master     tvalid tready tdata tuser    status, node and distance
//   cfg_     write      wr_en wr_data                root node id
//
// One request is worked at a time; the ancestor table is read once per cycle on each port.
// An attach writes one table level per cycle.
// A climb reads the table once per jump, a common-ancestor walk once per level and per jump.
// Reset and every root write start a clearing pass over the node store;
// no request is taken until it ends. A stalled result holds in the output register.
module tree_ancestor_lca_engine_core #(
  parameter int NODES  = talca_pkg::NODES_DEF,
  parameter int LEVELS = talca_pkg::LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [talca_pkg::ID_W-1:0]          cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // node_a [9:0], node_b [19:10], k_steps [29:20], zero fill [31:30]
  input  logic [talca_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode [1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_node [9:0], distance [20:10], zero fill [23:21]
  output logic [talca_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status [1:0]
  output logic [1:0]                          out_tuser
);

  talca_pkg::node_id_t               root_r;
  logic                              node_busy;
  talca_pkg::node_id_t               node_rd_id;
  talca_pkg::node_wr_t               node_wr;
  talca_pkg::node_rd_t               node_rd;
  talca_pkg::anc_req_t               anc_rd0_req;
  talca_pkg::anc_req_t               anc_rd1_req;
  talca_pkg::anc_wr_t                anc_wr;
  talca_pkg::anc_entry_t             anc_rd0;
  talca_pkg::anc_entry_t             anc_rd1;
  talca_pkg::status_t                out_status;
  talca_pkg::node_id_t               out_node;
  logic [talca_pkg::DIST_W-1:0]      out_dist;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_wr_en) begin
      root_r <= cfg_wr_data;
    end
  end

  talca_node_store #(
    .NODES (NODES)
  ) u_node_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_req (cfg_wr_en),
    .root      (root_r),
    .rd_id     (node_rd_id),
    .wr        (node_wr),
    .busy      (node_busy),
    .rd        (node_rd)
  );

  talca_anc_store #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_anc_store (
    .clk     (clk),
    .root    (root_r),
    .rd0_req (anc_rd0_req),
    .rd1_req (anc_rd1_req),
    .wr      (anc_wr),
    .rd0     (anc_rd0),
    .rd1     (anc_rd1)
  );

  talca_ctrl #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_mode     (talca_pkg::mode_t'(in_tuser)),
    .in_node_a   (in_tdata[9:0]),
    .in_node_b   (in_tdata[19:10]),
    .in_k_steps  (in_tdata[29:20]),
    .cfg_wr_en   (cfg_wr_en),
    .node_busy   (node_busy),
    .node_rd_id  (node_rd_id),
    .node_wr     (node_wr),
    .node_rd     (node_rd),
    .anc_rd0_req (anc_rd0_req),
    .anc_rd1_req (anc_rd1_req),
    .anc_wr      (anc_wr),
    .anc_rd0     (anc_rd0),
    .anc_rd1     (anc_rd1),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (out_status),
    .out_node    (out_node),
    .out_dist    (out_dist)
  );

  assign out_tdata = {3'b000, out_dist, out_node};
  assign out_tuser = out_status;

endmodule

@@ rtl/talca_checker.sv @@
// Port-level checks of the engine, bound to the top level.
module talca_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_wr_en,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [talca_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [1:0]                        out_tuser
);

  // A root write starts the clearing pass, which holds off requests.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready)
    else $error("request taken straight after a root write");

  // Requests are worked one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while another is in progress");

  // A failed request reports no node and no distance.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != 2'(talca_pkg::ST_OK))) |-> (out_tdata == '0))
    else $error("non-zero payload with an error status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind tree_ancestor_lca_engine_core talca_checker u_talca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_wr_en  (cfg_wr_en),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
